/* rtl/pta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants of the pixel tone adjust unit.
// ----------------------------------------------------------------------------
package pta_pkg;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned OFF_W  = 9;
	localparam int unsigned GRAY_W = 8;
	localparam int unsigned Y16_W  = 24;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned CFG_IDX_W  = 2;

	// Luma weights 0.299 / 0.587 / 0.114 in units of 2^-16, summing to 2^16
	localparam logic [15:0] LUMA_CR = 16'd19595;
	localparam logic [15:0] LUMA_CG = 16'd38470;
	localparam logic [15:0] LUMA_CB = 16'd7471;

	// Half of 255 * 2^16, the rounding term applied before the shift by 16
	localparam logic [31:0] HALF_SCALE = 32'd8355840;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TONE_RED   = 2'd0,
		REG_TONE_GREEN = 2'd1,
		REG_TONE_BLUE  = 2'd2,
		REG_TONE_GRAY  = 2'd3
	} reg_idx_t;

	// Load enables of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

/* rtl/pta_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_in_if
// Source pixel channel: valid/ready handshake with one RGBA word.
// ----------------------------------------------------------------------------
interface pta_in_if;
	logic                    valid;
	logic                    ready;
	logic [pta_pkg::CH_W-1:0] red_in;
	logic [pta_pkg::CH_W-1:0] green_in;
	logic [pta_pkg::CH_W-1:0] blue_in;
	logic [pta_pkg::CH_W-1:0] alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

/* rtl/pta_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_out_if
// Toned pixel channel: valid/ready handshake with one RGBA word.
// ----------------------------------------------------------------------------
interface pta_out_if;
	logic                    valid;
	logic                    ready;
	logic [pta_pkg::CH_W-1:0] red_out;
	logic [pta_pkg::CH_W-1:0] green_out;
	logic [pta_pkg::CH_W-1:0] blue_out;
	logic [pta_pkg::CH_W-1:0] alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

/* rtl/pixel_tone_adjust_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_tone_adjust_unit
// RGBA tone adjust: per-channel offset with optional desaturation to luma.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pix_in.ready is high, through a four-stage
// pipeline: luma, products, rounding and divide by 255, then offset and
// clamp. pix_in.ready drops only when all four stages hold a word and the
// sink is stalling. Tone registers are written through cfg_wr_en/cfg_index/
// cfg_data and must only change while the pipeline is empty; each of the
// four index values selects a tone register. Alpha passes through untouched.
module pixel_tone_adjust_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pta_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pta_pkg::CFG_DATA_W-1:0]    cfg_data,
	pta_in_if.sink                            pix_in,
	pta_out_if.source                         pix_out
);

	logic [pta_pkg::OFF_W-1:0]  tone_red_q;
	logic [pta_pkg::OFF_W-1:0]  tone_green_q;
	logic [pta_pkg::OFF_W-1:0]  tone_blue_q;
	logic [pta_pkg::GRAY_W-1:0] tone_gray_q;

	pta_pkg::stage_en_t en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [pta_pkg::CH_W-1:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4;
	logic [pta_pkg::CH_W-1:0] red_s1, green_s1, blue_s1;
	logic [pta_pkg::Y16_W-1:0] y16_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_red_q   <= '0;
			tone_green_q <= '0;
			tone_blue_q  <= '0;
			tone_gray_q  <= '0;
		end else if (cfg_wr_en) begin
			case (pta_pkg::reg_idx_t'(cfg_index))
				pta_pkg::REG_TONE_RED:   tone_red_q   <= cfg_data;
				pta_pkg::REG_TONE_GREEN: tone_green_q <= cfg_data;
				pta_pkg::REG_TONE_BLUE:  tone_blue_q  <= cfg_data;
				pta_pkg::REG_TONE_GRAY:  tone_gray_q  <= cfg_data[pta_pkg::GRAY_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its word moves on
	always_comb begin
		en.s4 = !v_s4 || pix_out.ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign pix_in.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= pix_in.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) alpha_s1 <= pix_in.alpha_in;
		if (en.s2) alpha_s2 <= alpha_s1;
		if (en.s3) alpha_s3 <= alpha_s2;
		if (en.s4) alpha_s4 <= alpha_s3;
	end

	pta_luma u_luma (
		.clk      (clk),
		.en       (en),
		.red      (pix_in.red_in),
		.green    (pix_in.green_in),
		.blue     (pix_in.blue_in),
		.red_s1   (red_s1),
		.green_s1 (green_s1),
		.blue_s1  (blue_s1),
		.y16_s1   (y16_s1)
	);

	pta_chan u_chan_red (
		.clk     (clk),
		.en      (en),
		.chan_s1 (red_s1),
		.y16_s1  (y16_s1),
		.gray    (tone_gray_q),
		.offset  (tone_red_q),
		.chan_s4 (pix_out.red_out)
	);

	pta_chan u_chan_green (
		.clk     (clk),
		.en      (en),
		.chan_s1 (green_s1),
		.y16_s1  (y16_s1),
		.gray    (tone_gray_q),
		.offset  (tone_green_q),
		.chan_s4 (pix_out.green_out)
	);

	pta_chan u_chan_blue (
		.clk     (clk),
		.en      (en),
		.chan_s1 (blue_s1),
		.y16_s1  (y16_s1),
		.gray    (tone_gray_q),
		.offset  (tone_blue_q),
		.chan_s4 (pix_out.blue_out)
	);

	assign pix_out.valid     = v_s4;
	assign pix_out.alpha_out = alpha_s4;

`ifndef ASSERT_OFF
	a_fill_from_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(pix_in.valid && pix_in.ready))
		else $error("stage 1 filled without an accepted input word");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !pix_out.ready))
		else $error("input stalled while the pipeline has room");

	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en.s4) |=> v_s3)
		else $error("stage 3 word dropped while stage 4 stalled");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en.s3) |=> v_s3)
		else $error("stage 2 word lost on advance");
`endif

endmodule

/* rtl/pta_luma.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_luma
// Stage 1: capture the color channels and form luma Y in Q16.
// ----------------------------------------------------------------------------
module pta_luma (
	input  logic                        clk,
	input  pta_pkg::stage_en_t          en,
	input  logic [pta_pkg::CH_W-1:0]    red,
	input  logic [pta_pkg::CH_W-1:0]    green,
	input  logic [pta_pkg::CH_W-1:0]    blue,
	output logic [pta_pkg::CH_W-1:0]    red_s1,
	output logic [pta_pkg::CH_W-1:0]    green_s1,
	output logic [pta_pkg::CH_W-1:0]    blue_s1,
	output logic [pta_pkg::Y16_W-1:0]   y16_s1
);

	logic [pta_pkg::Y16_W-1:0] y16;

	// Weights sum to 2^16, so the total stays below 256 * 2^16
	always_comb begin
		y16 = pta_pkg::Y16_W'(pta_pkg::LUMA_CR * {16'd0, red})
			+ pta_pkg::Y16_W'(pta_pkg::LUMA_CG * {16'd0, green})
			+ pta_pkg::Y16_W'(pta_pkg::LUMA_CB * {16'd0, blue});
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			y16_s1   <= y16;
		end
	end

endmodule

/* rtl/pta_chan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_chan
// Stages 2 to 4 of one color channel: blend toward luma, round, divide by
// 255, add the offset and clamp.
// ----------------------------------------------------------------------------
module pta_chan (
	input  logic                         clk,
	input  pta_pkg::stage_en_t           en,
	input  logic [pta_pkg::CH_W-1:0]     chan_s1,
	input  logic [pta_pkg::Y16_W-1:0]    y16_s1,
	input  logic [pta_pkg::GRAY_W-1:0]   gray,
	input  logic [pta_pkg::OFF_W-1:0]    offset,
	output logic [pta_pkg::CH_W-1:0]     chan_s4
);

	// stage 2 products
	logic [15:0] pc_s2;
	logic [31:0] py_s2;
	// stage 3 quotient estimate
	logic [16:0] u_s3;
	logic [7:0]  q0_s3;

	logic [31:0] blend;
	logic [16:0] u;
	logic [24:0] prod;
	logic [16:0] q0_ext;
	logic [16:0] rem;
	logic [8:0]  q_fix;
	logic signed [10:0] sum;
	logic [7:0]  res;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pc_s2 <= {8'd0, chan_s1} * {8'd0, 8'd255 - gray};
			py_s2 <= {8'd0, y16_s1} * {24'd0, gray};
		end
	end

	// u = floor((2N + S) / 2^17) with S = 255 * 2^16; q0 = floor(u*257 / 2^16)
	// lies one below floor(u / 255) at most
	always_comb begin
		blend = {pc_s2, 16'd0} + py_s2;
		u     = 17'((33'(blend) + 33'(pta_pkg::HALF_SCALE)) >> 16);
		prod  = {8'd0, u} + {u, 8'd0};
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			u_s3  <= u;
			q0_s3 <= prod[23:16];
		end
	end

	always_comb begin
		q0_ext = {9'd0, q0_s3};
		rem    = u_s3 - ((q0_ext << 8) - q0_ext);
		q_fix  = {1'b0, q0_s3} + {8'd0, (rem >= 17'd255)};
		sum    = $signed({2'b00, q_fix}) + $signed({{2{offset[pta_pkg::OFF_W-1]}}, offset});
		if (sum < 0) begin
			res = 8'd0;
		end else if (sum > 11'sd255) begin
			res = 8'd255;
		end else begin
			res = sum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			chan_s4 <= res;
		end
	end

endmodule
